[hdl/vna_pkg.sv]
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants of the vertex normal accumulator: transaction
// structs, command and operation codes, fixed-point widths.
// ----------------------------------------------------------------------------
package vna_pkg;

	// field widths
	localparam int IDX_W      = 10;
	localparam int COORD_W    = 20;
	localparam int DIFF_W     = COORD_W + 1;
	localparam int PROD_W     = 2 * DIFF_W;
	localparam int CROSS_W    = PROD_W + 1;
	localparam int SUM_W      = 52;
	localparam int NRM_W      = 16;

	// normalize unit widths
	localparam int FRAC_SHIFT = 14;
	localparam int MAG_LIM_W  = 30;

	// saturation bounds of an accumulator component
	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	// input commands
	localparam logic [1:0] CMD_STORE = 2'd0;
	localparam logic [1:0] CMD_TRI   = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	// classified operations passed from front to back
	localparam logic [2:0] OP_STORE    = 3'd0;
	localparam logic [2:0] OP_TRI      = 3'd1;
	localparam logic [2:0] OP_READ     = 3'd2;
	localparam logic [2:0] OP_READ_OOR = 3'd3;
	localparam logic [2:0] OP_CLEAR    = 3'd4;

	typedef struct packed {
		logic [1:0]                cmd;
		logic [IDX_W-1:0]          index_a;
		logic [IDX_W-1:0]          index_b;
		logic [IDX_W-1:0]          index_c;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
	} in_t;

	typedef struct packed {
		logic signed [NRM_W-1:0] normal_x;
		logic signed [NRM_W-1:0] normal_y;
		logic signed [NRM_W-1:0] normal_z;
		logic                    normal_ok;
		logic                    saturated;
	} out_t;

	typedef struct packed {
		logic [2:0]                kind;
		logic [IDX_W-1:0]          idx_a;
		logic [IDX_W-1:0]          idx_b;
		logic [IDX_W-1:0]          idx_c;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} op_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] x;
		logic signed [SUM_W-1:0] y;
		logic signed [SUM_W-1:0] z;
	} vec_t;

	typedef struct packed {
		logic signed [NRM_W-1:0] x;
		logic signed [NRM_W-1:0] y;
		logic signed [NRM_W-1:0] z;
		logic                    ok;
	} unit_t;

	typedef struct packed {
		logic touched;
		logic sat;
		vec_t sum;
	} acc_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} pos_t;

endpackage

[hdl/vna_front.sv]
// ----------------------------------------------------------------------------
// vna_front
// Accepts input transactions, checks indexes against the vertex count,
// turns each kept command into an operation and queues it for the back end.
// ----------------------------------------------------------------------------
module vna_front #(
	parameter int VERTEX_SLOTS = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  vna_pkg::in_t   item,
	output logic           full,
	input  logic           hold,
	output logic           op_valid,
	output vna_pkg::op_t   op,
	input  logic           op_pop
);
	import vna_pkg::*;

	localparam int QD    = 2;
	localparam int PTR_W = $clog2(QD);

	op_t              q_q [QD];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   cnt_q;
	logic             accept;
	logic             keep;
	logic             enq;
	op_t              cls;

	function automatic logic in_range(logic [IDX_W-1:0] i);
		return 32'(i) < VERTEX_SLOTS;
	endfunction

	// classify the command, drop stores and triangles that name a missing vertex
	always_comb begin
		cls.idx_a = item.index_a;
		cls.idx_b = item.index_b;
		cls.idx_c = item.index_c;
		cls.x     = item.coord_x;
		cls.y     = item.coord_y;
		cls.z     = item.coord_z;
		cls.kind  = OP_CLEAR;
		keep      = 1'b1;
		unique case (item.cmd)
			CMD_STORE: begin
				cls.kind = OP_STORE;
				keep     = in_range(item.index_a);
			end
			CMD_TRI: begin
				cls.kind = OP_TRI;
				keep     = in_range(item.index_a) && in_range(item.index_b)
					&& in_range(item.index_c);
			end
			CMD_READ: begin
				cls.kind = in_range(item.index_a) ? OP_READ : OP_READ_OOR;
			end
			default: begin
				cls.kind = OP_CLEAR;
			end
		endcase
	end

	// operation queue
	assign full     = hold || (cnt_q == (PTR_W+1)'(QD));
	assign accept   = push && !full;
	assign enq      = accept && keep;
	assign op_valid = cnt_q != '0;
	assign op       = q_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) wr_q <= wr_q + 1'b1;
			if (op_pop) rd_q <= rd_q + 1'b1;
			if (enq && !op_pop) cnt_q <= cnt_q + 1'b1;
			else if (!enq && op_pop) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (enq) q_q[wr_q] <= cls;
	end

endmodule

[hdl/vna_norm.sv]
// ----------------------------------------------------------------------------
// vna_norm
// Iterative normalize unit: turns a 52-bit vector into a Q1.14 unit vector
// by a scaling shift, a sum of squares, a bitwise square root and three
// restoring divisions.
// ----------------------------------------------------------------------------
module vna_norm (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  vna_pkg::vec_t   vec,
	output logic            busy,
	output logic            done,
	output vna_pkg::unit_t  res
);
	import vna_pkg::*;

	localparam logic [2:0] N_IDLE  = 3'd0;
	localparam logic [2:0] N_SHIFT = 3'd1;
	localparam logic [2:0] N_SQ    = 3'd2;
	localparam logic [2:0] N_SQRT  = 3'd3;
	localparam logic [2:0] N_DINIT = 3'd4;
	localparam logic [2:0] N_DIV   = 3'd5;
	localparam logic [2:0] N_DONE  = 3'd6;

	localparam int SQ_W   = 2 * MAG_LIM_W;
	localparam int RAD_W  = SQ_W + 2;
	localparam int ROOT_W = MAG_LIM_W + 1;
	localparam int NUM_W  = MAG_LIM_W + FRAC_SHIFT + 1;
	localparam int QUO_W  = FRAC_SHIFT + 1;
	localparam int IT_W   = $clog2(QUO_W);

	logic [2:0]             state_q;
	logic [1:0]             comp_q;
	logic [IT_W-1:0]        it_q;
	logic [SUM_W-1:0]       mag_q [3];
	logic                   neg_q [3];
	logic [SQ_W-1:0]        sq_q;
	logic [RAD_W-1:0]       n_q;
	logic [RAD_W-1:0]       root_q;
	logic [RAD_W-1:0]       bit_q;
	logic [NUM_W-1:0]       rem_q;
	logic [NUM_W-1:0]       dv_q;
	logic [QUO_W-1:0]       quo_q;
	unit_t                  res_q;

	logic                   all_zero;
	logic                   big;
	logic [MAG_LIM_W-1:0]   cur_mag;
	logic                   cur_neg;
	logic [RAD_W:0]         trial;
	logic                   ge;
	logic [QUO_W-1:0]       quo_nx;
	logic [NRM_W-1:0]       comp_val;
	logic [ROOT_W-1:0]      root;

	function automatic logic [SUM_W-1:0] mag(logic [SUM_W-1:0] v);
		return v[SUM_W-1] ? (~v + 1'b1) : v;
	endfunction

	// per-cycle helpers
	always_comb begin
		all_zero = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);
		big      = (|mag_q[0][SUM_W-1:MAG_LIM_W]) || (|mag_q[1][SUM_W-1:MAG_LIM_W])
			|| (|mag_q[2][SUM_W-1:MAG_LIM_W]);
		unique case (comp_q)
			2'd0: begin
				cur_mag = mag_q[0][MAG_LIM_W-1:0];
				cur_neg = neg_q[0];
			end
			2'd1: begin
				cur_mag = mag_q[1][MAG_LIM_W-1:0];
				cur_neg = neg_q[1];
			end
			default: begin
				cur_mag = mag_q[2][MAG_LIM_W-1:0];
				cur_neg = neg_q[2];
			end
		endcase
		trial    = {1'b0, root_q} + {1'b0, bit_q};
		root     = root_q[ROOT_W-1:0];
		ge       = rem_q >= dv_q;
		quo_nx   = {quo_q[QUO_W-2:0], ge};
		comp_val = cur_neg ? (~NRM_W'(quo_nx) + 1'b1) : NRM_W'(quo_nx);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			comp_q  <= '0;
			it_q    <= '0;
		end else begin
			unique case (state_q)
				N_IDLE: begin
					if (start) state_q <= N_SHIFT;
				end
				N_SHIFT: begin
					if (all_zero) begin
						state_q <= N_DONE;
					end else if (!big) begin
						comp_q  <= '0;
						state_q <= N_SQ;
					end
				end
				N_SQ: begin
					if (comp_q == 2'd3) begin
						state_q <= N_SQRT;
					end
					comp_q <= comp_q + 1'b1;
				end
				N_SQRT: begin
					if (bit_q == RAD_W'(1)) begin
						comp_q  <= '0;
						state_q <= N_DINIT;
					end
				end
				N_DINIT: begin
					it_q    <= '0;
					state_q <= N_DIV;
				end
				N_DIV: begin
					it_q <= it_q + 1'b1;
					if (it_q == IT_W'(QUO_W-1)) begin
						if (comp_q == 2'd2) begin
							state_q <= N_DONE;
						end else begin
							comp_q  <= comp_q + 1'b1;
							state_q <= N_DINIT;
						end
					end
				end
				N_DONE: begin
					state_q <= N_IDLE;
				end
				default: begin
					state_q <= N_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			N_IDLE: begin
				if (start) begin
					mag_q[0] <= mag(vec.x);
					mag_q[1] <= mag(vec.y);
					mag_q[2] <= mag(vec.z);
					neg_q[0] <= vec.x[SUM_W-1];
					neg_q[1] <= vec.y[SUM_W-1];
					neg_q[2] <= vec.z[SUM_W-1];
				end
			end
			N_SHIFT: begin
				n_q <= '0;
				if (all_zero) begin
					res_q <= '0;
				end else if (big) begin
					mag_q[0] <= mag_q[0] >> 1;
					mag_q[1] <= mag_q[1] >> 1;
					mag_q[2] <= mag_q[2] >> 1;
				end
			end
			N_SQ: begin
				// one square a cycle, summed in the next cycle
				sq_q <= cur_mag * cur_mag;
				if (comp_q != 2'd0) n_q <= n_q + RAD_W'(sq_q);
				root_q <= '0;
				bit_q  <= RAD_W'(1) << (RAD_W - 2);
			end
			N_SQRT: begin
				// one result bit a cycle
				if ({1'b0, n_q} >= trial) begin
					n_q    <= n_q - trial[RAD_W-1:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			N_DINIT: begin
				// rounded numerator and divisor aligned to the top quotient bit
				rem_q <= {1'b0, cur_mag, {FRAC_SHIFT{1'b0}}} + NUM_W'(root >> 1);
				dv_q  <= {root, {FRAC_SHIFT{1'b0}}};
				quo_q <= '0;
			end
			N_DIV: begin
				if (ge) rem_q <= rem_q - dv_q;
				dv_q  <= dv_q >> 1;
				quo_q <= quo_nx;
				if (it_q == IT_W'(QUO_W-1)) begin
					unique case (comp_q)
						2'd0:    res_q.x <= comp_val;
						2'd1:    res_q.y <= comp_val;
						default: res_q.z <= comp_val;
					endcase
					res_q.ok <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = state_q != N_IDLE;
	assign done = state_q == N_DONE;
	assign res  = res_q;

endmodule

[hdl/vna_outq.sv]
// ----------------------------------------------------------------------------
// vna_outq
// Two-entry result queue between the back end and the result port.
// ----------------------------------------------------------------------------
module vna_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  vna_pkg::out_t din,
	output logic          busy_full,
	input  logic          pop,
	output logic          empty,
	output vna_pkg::out_t dout
);
	import vna_pkg::*;

	localparam int QD    = 2;
	localparam int PTR_W = $clog2(QD);

	out_t             q_q [QD];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   cnt_q;
	logic             deq;

	assign busy_full = cnt_q == (PTR_W+1)'(QD);
	assign empty     = cnt_q == '0;
	assign deq       = pop && !empty;
	assign dout      = q_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wr_q <= wr_q + 1'b1;
			if (deq) rd_q <= rd_q + 1'b1;
			if (wr && !deq) cnt_q <= cnt_q + 1'b1;
			else if (!wr && deq) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) q_q[wr_q] <= din;
	end

endmodule

[hdl/vna_back.sv]
// ----------------------------------------------------------------------------
// vna_back
// Executes queued operations: position and accumulator memories, the
// shared cross-product multiplier, saturating read-modify-write of the three
// corners, accumulator reads and the clearing sweep.
// ----------------------------------------------------------------------------
module vna_back #(
	parameter int VERTEX_SLOTS = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            weight_mode,
	input  logic            op_valid,
	input  vna_pkg::op_t    op,
	output logic            op_pop,
	output logic            init_busy,
	output logic            res_push,
	output vna_pkg::out_t   res,
	input  logic            res_full,
	output logic            nrm_start,
	output vna_pkg::vec_t   nrm_vec,
	input  logic            nrm_done,
	input  vna_pkg::unit_t  nrm_res
);
	import vna_pkg::*;

	localparam int IDX_SPAN = 2 ** IDX_W;
	localparam int DEPTH    = (VERTEX_SLOTS < IDX_SPAN) ? VERTEX_SLOTS : IDX_SPAN;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	localparam logic [3:0] S_INIT    = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_CLR     = 4'd2;
	localparam logic [3:0] S_TRI_RD  = 4'd3;
	localparam logic [3:0] S_MUL     = 4'd4;
	localparam logic [3:0] S_CROSS   = 4'd5;
	localparam logic [3:0] S_TRI_NRM = 4'd6;
	localparam logic [3:0] S_ACC_RD  = 4'd7;
	localparam logic [3:0] S_ACC_DAT = 4'd8;
	localparam logic [3:0] S_RD_DAT  = 4'd9;
	localparam logic [3:0] S_RD_NRM  = 4'd10;
	localparam logic [3:0] S_OUT     = 4'd11;

	// memories
	pos_t pos_mem [DEPTH];
	acc_t acc_mem [DEPTH];

	logic [3:0]              state_q, state_d;
	logic [2:0]              step_q, step_d;
	logic [ADDR_W-1:0]       clr_addr_q, clr_addr_d;
	op_t                     op_q;
	pos_t                    p0_q, p1_q, pos_rd_q;
	acc_t                    acc_rd_q;
	logic signed [DIFF_W-1:0]  d1_q [3];
	logic signed [DIFF_W-1:0]  d2_q [3];
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [CROSS_W-1:0] cr_q [3];
	vec_t                    add_q;
	out_t                    res_q;

	logic                    pos_we;
	logic [ADDR_W-1:0]       pos_waddr, pos_raddr;
	pos_t                    pos_wdata;
	logic                    acc_we;
	logic [ADDR_W-1:0]       acc_waddr, acc_raddr;
	acc_t                    acc_wdata;
	logic signed [DIFF_W-1:0] mul_a, mul_b;
	logic [2:0]              prev;
	logic                    cross_zero;
	logic [SUM_W:0]          sx, sy, sz;

	function automatic logic [ADDR_W-1:0] corner(op_t o, logic [1:0] k);
		logic [IDX_W-1:0] i;
		unique case (k)
			2'd0:    i = o.idx_a;
			2'd1:    i = o.idx_b;
			default: i = o.idx_c;
		endcase
		return i[ADDR_W-1:0];
	endfunction

	function automatic logic [DIFF_W-1:0] dif(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
		return {a[COORD_W-1], a} - {b[COORD_W-1], b};
	endfunction

	function automatic logic [SUM_W-1:0] ext_cr(logic [CROSS_W-1:0] v);
		return {{(SUM_W-CROSS_W){v[CROSS_W-1]}}, v};
	endfunction

	function automatic logic [SUM_W-1:0] ext_nrm(logic [NRM_W-1:0] v);
		return {{(SUM_W-NRM_W){v[NRM_W-1]}}, v};
	endfunction

	// returns overflow flag over the clamped sum
	function automatic logic [SUM_W:0] sat_add(logic [SUM_W-1:0] s, logic [SUM_W-1:0] d);
		logic [SUM_W:0] t;
		t = {s[SUM_W-1], s} + {d[SUM_W-1], d};
		if (t[SUM_W] != t[SUM_W-1]) return {1'b1, t[SUM_W] ? SUM_MIN : SUM_MAX};
		return {1'b0, t[SUM_W-1:0]};
	endfunction

	assign sx = sat_add(acc_rd_q.sum.x, add_q.x);
	assign sy = sat_add(acc_rd_q.sum.y, add_q.y);
	assign sz = sat_add(acc_rd_q.sum.z, add_q.z);
	assign cross_zero = (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);
	assign prev = step_q - 3'd1;

	// sequencer
	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		clr_addr_d = clr_addr_q;
		op_pop     = 1'b0;
		pos_we     = 1'b0;
		pos_waddr  = op.idx_a[ADDR_W-1:0];
		pos_wdata  = {op.x, op.y, op.z};
		pos_raddr  = op.idx_a[ADDR_W-1:0];
		acc_we     = 1'b0;
		acc_waddr  = clr_addr_q;
		acc_wdata  = '0;
		acc_raddr  = op.idx_a[ADDR_W-1:0];
		nrm_start  = 1'b0;
		res_push   = 1'b0;
		unique case (state_q)
			S_INIT, S_CLR: begin
				acc_we     = 1'b1;
				clr_addr_d = clr_addr_q + 1'b1;
				if (clr_addr_q == LAST_ADDR) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (op_valid) begin
					op_pop = 1'b1;
					unique case (op.kind)
						OP_STORE: pos_we = 1'b1;
						OP_CLEAR: begin
							clr_addr_d = '0;
							state_d    = S_CLR;
						end
						OP_READ:     state_d = S_RD_DAT;
						OP_READ_OOR: state_d = S_OUT;
						OP_TRI: begin
							step_d  = '0;
							state_d = S_TRI_RD;
						end
						default: begin
						end
					endcase
				end
			end
			S_TRI_RD: begin
				pos_raddr = corner(op_q, step_q[1:0] + 2'd1);
				if (step_q == 3'd2) begin
					step_d  = '0;
					state_d = S_MUL;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_MUL: begin
				step_d = step_q + 1'b1;
				if (step_q == 3'd6) state_d = S_CROSS;
			end
			S_CROSS: begin
				step_d = '0;
				if (weight_mode) begin
					state_d = S_ACC_RD;
				end else if (cross_zero) begin
					state_d = S_IDLE;
				end else begin
					nrm_start = 1'b1;
					state_d   = S_TRI_NRM;
				end
			end
			S_TRI_NRM: begin
				if (nrm_done) state_d = S_ACC_RD;
			end
			S_ACC_RD: begin
				acc_raddr = corner(op_q, step_q[1:0]);
				state_d   = S_ACC_DAT;
			end
			S_ACC_DAT: begin
				acc_we            = 1'b1;
				acc_waddr         = corner(op_q, step_q[1:0]);
				acc_wdata.touched = 1'b1;
				acc_wdata.sat     = acc_rd_q.sat | sx[SUM_W] | sy[SUM_W] | sz[SUM_W];
				acc_wdata.sum.x   = sx[SUM_W-1:0];
				acc_wdata.sum.y   = sy[SUM_W-1:0];
				acc_wdata.sum.z   = sz[SUM_W-1:0];
				if (step_q == 3'd2) begin
					state_d = S_IDLE;
				end else begin
					step_d  = step_q + 1'b1;
					state_d = S_ACC_RD;
				end
			end
			S_RD_DAT: begin
				if (acc_rd_q.touched) begin
					nrm_start = 1'b1;
					state_d   = S_RD_NRM;
				end else begin
					state_d = S_OUT;
				end
			end
			S_RD_NRM: begin
				if (nrm_done) state_d = S_OUT;
			end
			S_OUT: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// cross product operand select, one product a cycle
	always_comb begin
		unique case (step_q)
			3'd0: begin mul_a = d1_q[1]; mul_b = d2_q[2]; end
			3'd1: begin mul_a = d1_q[2]; mul_b = d2_q[1]; end
			3'd2: begin mul_a = d1_q[2]; mul_b = d2_q[0]; end
			3'd3: begin mul_a = d1_q[0]; mul_b = d2_q[2]; end
			3'd4: begin mul_a = d1_q[0]; mul_b = d2_q[1]; end
			3'd5: begin mul_a = d1_q[1]; mul_b = d2_q[0]; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign nrm_vec   = (state_q == S_RD_DAT) ? acc_rd_q.sum
		: {ext_cr(cr_q[0]), ext_cr(cr_q[1]), ext_cr(cr_q[2])};
	assign res       = res_q;
	assign init_busy = state_q == S_INIT;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			step_q     <= '0;
			clr_addr_q <= '0;
		end else begin
			state_q    <= state_d;
			step_q     <= step_d;
			clr_addr_q <= clr_addr_d;
		end
	end

	// memory ports, read data registered
	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
		pos_rd_q <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
		acc_rd_q <= acc_mem[acc_raddr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (op_pop) op_q <= op;
		if (op_pop && op.kind == OP_READ_OOR) res_q <= '0;

		// corner capture and edge vectors
		if (state_q == S_TRI_RD) begin
			if (step_q == 3'd0) p0_q <= pos_rd_q;
			if (step_q == 3'd1) p1_q <= pos_rd_q;
			if (step_q == 3'd2) begin
				d1_q[0] <= dif(p1_q.x, p0_q.x);
				d1_q[1] <= dif(p1_q.y, p0_q.y);
				d1_q[2] <= dif(p1_q.z, p0_q.z);
				d2_q[0] <= dif(pos_rd_q.x, p0_q.x);
				d2_q[1] <= dif(pos_rd_q.y, p0_q.y);
				d2_q[2] <= dif(pos_rd_q.z, p0_q.z);
			end
		end

		// multiply, then load or subtract the registered product
		if (state_q == S_MUL) begin
			prod_q <= mul_a * mul_b;
			if (step_q != 3'd0) begin
				if (!prev[0]) cr_q[prev[2:1]] <= {prod_q[PROD_W-1], prod_q};
				else cr_q[prev[2:1]] <= cr_q[prev[2:1]] - {prod_q[PROD_W-1], prod_q};
			end
		end

		// face contribution
		if (state_q == S_CROSS) begin
			add_q <= {ext_cr(cr_q[0]), ext_cr(cr_q[1]), ext_cr(cr_q[2])};
		end
		if (state_q == S_TRI_NRM && nrm_done) begin
			add_q <= {ext_nrm(nrm_res.x), ext_nrm(nrm_res.y), ext_nrm(nrm_res.z)};
		end

		// read result
		if (state_q == S_RD_DAT) begin
			res_q <= out_t'{normal_x: '0, normal_y: '0, normal_z: '0,
				normal_ok: 1'b0, saturated: acc_rd_q.sat};
		end
		if (state_q == S_RD_NRM && nrm_done) begin
			res_q.normal_x  <= nrm_res.x;
			res_q.normal_y  <= nrm_res.y;
			res_q.normal_z  <= nrm_res.z;
			res_q.normal_ok <= nrm_res.ok;
		end
	end

endmodule

[hdl/vertex_normal_accumulator.sv]
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Stores vertex positions and accumulates face normals per vertex; returns
// the normalized Q1.14 normal of a vertex on request.
//
// Input: push/full queue port carrying item (cmd, three indexes, position).
// A transaction is taken on a clock edge with push high and full low.
// Commands: store vertex, add triangle, read normal, clear accumulators.
// Only a read produces a result transaction on the result port (empty/pop).
// Configuration: cfg_we/cfg_wdata write weight_mode (0 uniform, 1 area);
// write it only while the block is idle.
// A store is one write; an area-weighted triangle reads three positions,
// forms six products on the shared multiplier and read-modify-writes three
// corners; a uniform triangle with a nonzero cross product and a read of a
// touched vertex also use the normalize unit (scaling shifts, squares, square
// root, three divisions). A clear sweeps the accumulator memory (at most 1024
// entries), one entry a cycle. Operations run one at a time in the back end;
// a two-entry queue lets the input keep taking transactions meanwhile.
// Reset: the same sweep runs after reset with full held high.
// A stalled result port fills the two-entry result queue, then the back end
// and finally the input queue wait; nothing is dropped.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator #(
	parameter int VERTEX_SLOTS = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  logic          push,
	output logic          full,
	input  vna_pkg::in_t  item,
	output logic          empty,
	input  logic          pop,
	output vna_pkg::out_t result
);
	import vna_pkg::*;

	logic  weight_mode_q;
	logic  op_valid;
	op_t   op;
	logic  op_pop;
	logic  init_busy;
	logic  res_push;
	out_t  res;
	logic  res_full;
	logic  nrm_start;
	vec_t  nrm_vec;
	logic  nrm_busy;
	logic  nrm_done;
	unit_t nrm_res;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) weight_mode_q <= 1'b0;
		else if (cfg_we) weight_mode_q <= cfg_wdata;
	end

	vna_front #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.hold     (init_busy),
		.op_valid (op_valid),
		.op       (op),
		.op_pop   (op_pop)
	);

	vna_back #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.weight_mode (weight_mode_q),
		.op_valid    (op_valid),
		.op          (op),
		.op_pop      (op_pop),
		.init_busy   (init_busy),
		.res_push    (res_push),
		.res         (res),
		.res_full    (res_full),
		.nrm_start   (nrm_start),
		.nrm_vec     (nrm_vec),
		.nrm_done    (nrm_done),
		.nrm_res     (nrm_res)
	);

	vna_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (nrm_start),
		.vec    (nrm_vec),
		.busy   (nrm_busy),
		.done   (nrm_done),
		.res    (nrm_res)
	);

	vna_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (res_push),
		.din       (res),
		.busy_full (res_full),
		.pop       (pop),
		.empty     (empty),
		.dout      (result)
	);

	// result queue never written while full
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full queue");

	// normalize unit only started while idle
	a_nrm_idle: assert property (@(posedge clk) disable iff (!arst_n)
		nrm_start |-> !nrm_busy)
		else $error("normalize unit restarted while busy");

	// a valid unit vector has a nonzero component
	a_unit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(nrm_done && nrm_res.ok) |-> (nrm_res.x != '0 || nrm_res.y != '0 || nrm_res.z != '0))
		else $error("valid normal with all components zero");

endmodule
